### design/dmx_pkg.sv
`default_nettype none

package dmx_pkg;

   // Request and result field widths
   localparam int unsigned SMP_W      = 24;
   localparam int unsigned CH_W       = 6;
   localparam int unsigned CNT_W      = 7;
   localparam int unsigned OUT_W      = 16;

   // Gain registers, Q1.14
   localparam int unsigned GAIN_W     = 15;
   localparam int unsigned GAIN_COUNT = 8;
   localparam int unsigned GAIN_IDX_W = $clog2(GAIN_COUNT);
   localparam int unsigned CSR_IDX_W  = 4;

   localparam logic [GAIN_W-1:0] GAIN_RESET [GAIN_COUNT] = '{
      GAIN_W'(16384), GAIN_W'(16384), GAIN_W'(11585), GAIN_W'(0),
      GAIN_W'(11585), GAIN_W'(11585), GAIN_W'(11585), GAIN_W'(11585)
   };

   // Accumulation in Q.34 units
   localparam int unsigned UNIT_SHIFT = 14;
   localparam int unsigned ADD_W      = SMP_W + GAIN_W + 1;
   localparam int unsigned SUM_W      = 48;
   localparam int unsigned ONE_SHIFT  = 34;
   localparam logic [SUM_W-1:0] ONE_Q34 = SUM_W'(1) << ONE_SHIFT;

   // Output scaling
   localparam int unsigned CLAMP_W    = ONE_SHIFT + 1;
   localparam logic [GAIN_W-1:0] FULL_SCALE = GAIN_W'(32767);
   localparam int unsigned PROD_W     = CLAMP_W + GAIN_W;

   // Left and right lanes of the back part
   localparam int unsigned LANES      = 2;
   localparam int unsigned LANE_L     = 0;
   localparam int unsigned LANE_R     = 1;
   localparam int unsigned STEP_W     = $clog2(SUM_W);

   // Defaults of the top level parameters
   localparam int unsigned MAX_CHANNELS_DEF = 64;
   localparam int unsigned QUEUE_DEPTH_DEF  = 2;

   // Channel counts with a matrix or mono mapping
   localparam logic [CNT_W-1:0] CNT_MONO   = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_STEREO = CNT_W'(2);
   localparam logic [CNT_W-1:0] CNT_5_1    = CNT_W'(6);
   localparam logic [CNT_W-1:0] CNT_7_1    = CNT_W'(8);

   // Matrix layout positions
   localparam logic [CH_W-1:0] CH_FL  = CH_W'(0);
   localparam logic [CH_W-1:0] CH_FR  = CH_W'(1);
   localparam logic [CH_W-1:0] CH_C   = CH_W'(2);
   localparam logic [CH_W-1:0] CH_LFE = CH_W'(3);
   localparam logic [CH_W-1:0] CH_SL  = CH_W'(4);
   localparam logic [CH_W-1:0] CH_SR  = CH_W'(5);
   localparam logic [CH_W-1:0] CH_BL  = CH_W'(6);
   localparam logic [CH_W-1:0] CH_BR  = CH_W'(7);

   typedef enum logic [1:0] {
      MODE_UNIT,
      MODE_MATRIX,
      MODE_AVG
   } dmx_mode_type;

   typedef enum logic [2:0] {
      BACK_IDLE,
      BACK_DIV,
      BACK_CLAMP,
      BACK_MUL,
      BACK_OUT
   } dmx_back_state_type;

   // One finished frame on its way from front to back
   typedef struct packed {
      logic signed [SUM_W-1:0] left_sum;
      logic signed [SUM_W-1:0] right_sum;
      logic                    avg;
      logic [CNT_W-1:0]        left_div;
      logic [CNT_W-1:0]        right_div;
   } dmx_frame_type;

endpackage

`default_nettype wire

### design/dmx_ifs.sv
`default_nettype none

interface dmx_req_if import dmx_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [SMP_W-1:0] sample_value;
   logic [CH_W-1:0]         channel_index;
   logic [CNT_W-1:0]        channel_count;

   modport source (output valid, sample_value, channel_index, channel_count, input ready);
   modport sink (input valid, sample_value, channel_index, channel_count, output ready);
endinterface

interface dmx_rsp_if import dmx_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] left_out;
   logic signed [OUT_W-1:0] right_out;

   modport source (output valid, left_out, right_out, input ready);
   modport sink (input valid, left_out, right_out, output ready);
endinterface

`default_nettype wire

### design/dmx_front.sv
`default_nettype none

module dmx_front import dmx_pkg::*; #(
   parameter int unsigned MAX_CHANNELS = MAX_CHANNELS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   dmx_req_if.sink                   req,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [GAIN_W-1:0]    csr_wdata,
   output logic                      push,
   output dmx_frame_type             push_entry,
   input  wire logic                 queue_full
);

   logic [GAIN_W-1:0] gain_ff [GAIN_COUNT];

   logic                    s1_valid_ff, s1_valid_in;
   logic signed [ADD_W-1:0] s1_l_ff, s1_r_ff;
   logic                    s1_first_ff, s1_last_ff, s1_avg_ff;
   logic [CNT_W-1:0]        s1_nl_ff, s1_nr_ff;

   logic signed [SUM_W-1:0] sum_l_ff, sum_r_ff;
   logic signed [SUM_W-1:0] new_l, new_r;

   logic                    accept, item_ok, s1_adv;
   dmx_mode_type            mode;
   logic signed [SMP_W-1:0] smp;
   logic [CH_W-1:0]         ch;
   logic [CNT_W-1:0]        cnt;
   logic signed [GAIN_W:0]  gain_s;
   logic signed [ADD_W-1:0] unit, prod, add_l, add_r;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < GAIN_COUNT; i++) begin
            gain_ff[i] <= GAIN_RESET[i];
         end
      end else if (csr_we && csr_index < CSR_IDX_W'(GAIN_COUNT)) begin
         gain_ff[csr_index[GAIN_IDX_W-1:0]] <= csr_wdata;
      end
   end

   assign smp = req.sample_value;
   assign ch  = req.channel_index;
   assign cnt = req.channel_count;

   assign item_ok = (cnt != '0) && ((CNT_W+1)'(cnt) <= (CNT_W+1)'(MAX_CHANNELS))
                    && (CNT_W'(ch) < cnt);

   assign unit   = {{(ADD_W-SMP_W-UNIT_SHIFT){smp[SMP_W-1]}}, smp, {UNIT_SHIFT{1'b0}}};
   assign gain_s = $signed({1'b0, gain_ff[ch[GAIN_IDX_W-1:0]]});
   assign prod   = smp * gain_s;

   always_comb begin
      unique case (cnt) inside
         CNT_MONO:                    mode = MODE_UNIT;
         CNT_STEREO, CNT_5_1, CNT_7_1: mode = MODE_MATRIX;
         default:                     mode = MODE_AVG;
      endcase
   end

   always_comb begin
      add_l = '0;
      add_r = '0;
      unique case (mode)
         MODE_UNIT: begin
            add_l = unit;
            add_r = unit;
         end
         MODE_MATRIX: begin
            unique case (ch) inside
               CH_FL, CH_SL, CH_BL: add_l = prod;
               CH_FR, CH_SR, CH_BR: add_r = prod;
               CH_C, CH_LFE: begin
                  add_l = prod;
                  add_r = prod;
               end
               default: ;
            endcase
         end
         default: begin
            if (ch[0]) add_r = unit;
            else       add_l = unit;
         end
      endcase
   end

   // Hold the staged request at frame end until the queue has room
   assign s1_adv    = s1_valid_ff && (!s1_last_ff || !queue_full);
   assign req.ready = !s1_valid_ff || s1_adv;
   assign accept    = req.valid && req.ready;

   always_comb begin
      if (accept && item_ok) s1_valid_in = 1'b1;
      else if (s1_adv)       s1_valid_in = 1'b0;
      else                   s1_valid_in = s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_l_ff     <= add_l;
         s1_r_ff     <= add_r;
         s1_first_ff <= (ch == '0);
         s1_last_ff  <= (CNT_W'(ch) + CNT_W'(1) == cnt);
         s1_avg_ff   <= (mode == MODE_AVG);
         s1_nl_ff    <= (cnt + CNT_W'(1)) >> 1;
         s1_nr_ff    <= cnt >> 1;
      end
   end

   // A frame start drops whatever the sums still hold
   assign new_l = (s1_first_ff ? '0 : sum_l_ff) + SUM_W'(s1_l_ff);
   assign new_r = (s1_first_ff ? '0 : sum_r_ff) + SUM_W'(s1_r_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_l_ff <= '0;
         sum_r_ff <= '0;
      end else if (s1_adv) begin
         sum_l_ff <= s1_last_ff ? '0 : new_l;
         sum_r_ff <= s1_last_ff ? '0 : new_r;
      end
   end

   assign push                 = s1_adv && s1_last_ff;
   assign push_entry.left_sum  = new_l;
   assign push_entry.right_sum = new_r;
   assign push_entry.avg       = s1_avg_ff;
   assign push_entry.left_div  = s1_nl_ff;
   assign push_entry.right_div = s1_nr_ff;

`ifndef ASSERT_OFF
   a_sums_clear: assert property (@(posedge clock) disable iff (reset)
      push |=> (sum_l_ff == '0 && sum_r_ff == '0))
      else $error("sums not cleared after frame end");

   a_drop_bad: assert property (@(posedge clock) disable iff (reset)
      accept && !item_ok |=> !s1_valid_ff)
      else $error("ignored request entered the pipeline");
`endif

endmodule

`default_nettype wire

### design/dmx_fifo.sv
`default_nettype none

module dmx_fifo import dmx_pkg::*; #(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire dmx_frame_type wr_entry,
   output logic               full,
   input  wire logic          pop,
   output dmx_frame_type      rd_entry,
   output logic               empty
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   dmx_frame_type   mem_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]   cnt_ff, cnt_in;

   assign full     = (cnt_ff == CW'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign rd_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop)      cnt_in = cnt_ff + CW'(1);
      else if (pop && !push) cnt_in = cnt_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_entry;
      end
   end

`ifndef ASSERT_OFF
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DEPTH))
      else $error("queue count out of range");

   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + CW'(1))
      else $error("queue count lost a push");
`endif

endmodule

`default_nettype wire

### design/dmx_div.sv
`default_nettype none

module dmx_div import dmx_pkg::*; (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [LANES-1:0][SUM_W-1:0]  dvd,
   input  wire logic [LANES-1:0][CNT_W-1:0]  dvs,
   output logic                              done,
   output logic [LANES-1:0][SUM_W-1:0]       quo
);

   logic                            busy_ff, done_ff;
   logic [STEP_W-1:0]               step_ff;
   logic [LANES-1:0][SUM_W-1:0]     quo_ff, quo_nx;
   logic [LANES-1:0][CNT_W-1:0]     rem_ff, rem_nx, dvs_ff;
   logic [LANES-1:0][CNT_W:0]       trial, diff;
   logic [LANES-1:0]                fit;

   // One restoring step per lane: shift in the next dividend bit
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         trial[i]  = {rem_ff[i], quo_ff[i][SUM_W-1]};
         diff[i]   = trial[i] - {1'b0, dvs_ff[i]};
         fit[i]    = (trial[i] >= {1'b0, dvs_ff[i]});
         rem_nx[i] = fit[i] ? diff[i][CNT_W-1:0] : trial[i][CNT_W-1:0];
         quo_nx[i] = {quo_ff[i][SUM_W-2:0], fit[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dvd;
         rem_ff <= '0;
         dvs_ff <= dvs;
      end else if (busy_ff) begin
         quo_ff <= quo_nx;
         rem_ff <= rem_nx;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

`default_nettype wire

### design/dmx_back.sv
`default_nettype none

module dmx_back import dmx_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          queue_empty,
   input  wire dmx_frame_type head,
   output logic               pop,
   dmx_rsp_if.source          rsp
);

   dmx_back_state_type state_ff, state_in;

   logic                            div_start, div_done, out_load;
   logic [LANES-1:0][SUM_W-1:0]     div_dvd, div_quo;
   logic [LANES-1:0][CNT_W-1:0]     div_dvs;
   logic [LANES-1:0][SUM_W-1:0]     sum_abs;
   logic [LANES-1:0]                sum_neg;

   logic [LANES-1:0][SUM_W-1:0]     mag_ff;
   logic [LANES-1:0]                neg_ff;
   logic [LANES-1:0][CLAMP_W-1:0]   clamp_ff;
   logic [LANES-1:0][PROD_W-1:0]    prod_ff;
   logic [LANES-1:0][OUT_W-1:0]     out_val;
   logic signed [OUT_W-1:0]         out_ff [LANES];
   logic                            rsp_valid_ff;

   // Work on magnitudes so every truncation goes toward zero
   always_comb begin
      sum_neg[LANE_L] = head.left_sum[SUM_W-1];
      sum_neg[LANE_R] = head.right_sum[SUM_W-1];
      sum_abs[LANE_L] = sum_neg[LANE_L] ? ~head.left_sum + SUM_W'(1) : head.left_sum;
      sum_abs[LANE_R] = sum_neg[LANE_R] ? ~head.right_sum + SUM_W'(1) : head.right_sum;
   end

   assign div_dvd          = sum_abs;
   assign div_dvs[LANE_L]  = head.left_div;
   assign div_dvs[LANE_R]  = head.right_div;

   dmx_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .dvd   (div_dvd),
      .dvs   (div_dvs),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      pop       = 1'b0;
      div_start = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         BACK_IDLE: begin
            if (!queue_empty) begin
               pop = 1'b1;
               if (head.avg) begin
                  div_start = 1'b1;
                  state_in  = BACK_DIV;
               end else begin
                  state_in  = BACK_CLAMP;
               end
            end
         end
         BACK_DIV: begin
            if (div_done) state_in = BACK_CLAMP;
         end
         BACK_CLAMP: state_in = BACK_MUL;
         BACK_MUL:   state_in = BACK_OUT;
         BACK_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               out_load = 1'b1;
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         out_val[i] = neg_ff[i] ? ~prod_ff[i][ONE_SHIFT +: OUT_W] + OUT_W'(1)
                                : prod_ff[i][ONE_SHIFT +: OUT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         mag_ff <= sum_abs;
         neg_ff <= sum_neg;
      end else if (div_done) begin
         mag_ff <= div_quo;
      end
      for (int i = 0; i < LANES; i++) begin
         if (state_ff == BACK_CLAMP) begin
            clamp_ff[i] <= (mag_ff[i] > ONE_Q34) ? ONE_Q34[CLAMP_W-1:0]
                                                  : mag_ff[i][CLAMP_W-1:0];
         end
         if (state_ff == BACK_MUL) begin
            prod_ff[i] <= PROD_W'(clamp_ff[i]) * PROD_W'(FULL_SCALE);
         end
         if (out_load) begin
            out_ff[i] <= out_val[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.left_out  = out_ff[LANE_L];
   assign rsp.right_out = out_ff[LANE_R];

`ifndef ASSERT_OFF
   a_div_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == BACK_DIV)
      else $error("divider finished outside the divide state");

   a_out_from_fsm: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == BACK_OUT)
      else $error("result raised outside the output state");
`endif

endmodule

`default_nettype wire

### design/multichannel_stereo_downmix_top.sv
`default_nettype none

// Stereo downmix of multichannel frames. Send one channel sample per request,
// in channel order, tagged with its index and the frame's channel count; the
// last channel of a frame yields one left/right result. The front takes one
// request per clock and accumulates, but holds a frame's last request while
// the frame queue is full; a finished frame goes through a small frame queue
// (QUEUE_DEPTH entries) to the back, which clamps and scales it. A mono or
// matrix frame (1, 2, 6, 8 channels) passes the clamp, multiply and output
// states; an averaged frame (any other count) first adds a 48-step bit-serial
// divide. Frames that arrive faster than the back finishes them fill the queue
// and the front holds requests; otherwise requests flow at one per clock.
// Gains are to be written through the csr port only while no frame is in
// flight; the block itself does not enforce this. A write with an index past
// the last gain is ignored.
module multichannel_stereo_downmix_top import dmx_pkg::*; #(
   parameter int unsigned MAX_CHANNELS = MAX_CHANNELS_DEF,
   parameter int unsigned QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   dmx_req_if.sink                   req_if,
   dmx_rsp_if.source                 rsp_if,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [GAIN_W-1:0]    csr_wdata
);

   logic          push, queue_full, pop, queue_empty;
   dmx_frame_type push_entry, head;

   dmx_front #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_if),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .push       (push),
      .push_entry (push_entry),
      .queue_full (queue_full)
   );

   dmx_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .wr_entry (push_entry),
      .full     (queue_full),
      .pop      (pop),
      .rd_entry (head),
      .empty    (queue_empty)
   );

   dmx_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head        (head),
      .pop         (pop),
      .rsp         (rsp_if)
   );

endmodule

`default_nettype wire

### verif/tb_multichannel_stereo_downmix_top.sv
module tb_multichannel_stereo_downmix_top;
   import dmx_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned HALF_PERIOD     = 4;
   localparam int unsigned SETTLE_CYCLES   = 100;
   localparam int unsigned QUIET_LIMIT     = 2000;
   localparam int unsigned PHASES          = 6;
   localparam int unsigned ITEMS_PER_PHASE = 300;
   localparam int unsigned ERRORS_SHOWN    = 10;

   localparam logic signed [SMP_W-1:0] SMP_ONE  = 24'sd1048576;
   localparam logic signed [SMP_W-1:0] SMP_HALF = 24'sd524288;
   localparam logic signed [SMP_W-1:0] SMP_MAX  = 24'sh7FFFFF;
   localparam logic signed [SMP_W-1:0] SMP_MIN  = 24'sh800000;
   localparam logic signed [OUT_W-1:0] PCM_MAX  = 16'sd32767;
   localparam logic signed [OUT_W-1:0] PCM_MIN  = -16'sd32767;
   localparam logic [CSR_IDX_W-1:0]    CSR_TOP  = '1;

   typedef struct packed {
      logic signed [OUT_W-1:0] left;
      logic signed [OUT_W-1:0] right;
   } stereo_pcm_type;

   typedef enum logic [1:0] {
      ROW_PREDICT,
      ROW_NONE,
      ROW_PAIR
   } row_kind_type;

   typedef struct packed {
      logic signed [SMP_W-1:0] smp;
      logic [CH_W-1:0]         ch;
      logic [CNT_W-1:0]        cnt;
      row_kind_type            kind;
      stereo_pcm_type          pair;
   } stimulus_row_type;

   localparam stereo_pcm_type PAIR_NONE = '0;
   localparam stereo_pcm_type PAIR_HIGH = '{PCM_MAX, PCM_MAX};
   localparam stereo_pcm_type PAIR_LOW  = '{PCM_MIN, PCM_MIN};
   localparam stereo_pcm_type PAIR_SPLIT = '{PCM_MAX, PCM_MIN};

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [GAIN_W-1:0] csr_wdata;

   dmx_req_if req_ch ();
   dmx_rsp_if rsp_ch ();

   logic [GAIN_W-1:0] gain_reg [GAIN_COUNT];
   longint left_acc;
   longint right_acc;
   stereo_pcm_type pcm_expected [$];
   int unsigned pcm_errors = 0;
   int unsigned quiet_cycles = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;

   stimulus_row_type directed_rows [24] = '{
      '{24'sd0, CH_FL, CNT_MONO, ROW_PAIR, PAIR_NONE},
      '{SMP_ONE, CH_FL, CNT_MONO, ROW_PAIR, PAIR_HIGH},
      '{SMP_MAX, CH_FL, CNT_MONO, ROW_PAIR, PAIR_HIGH},
      '{SMP_MIN, CH_FL, CNT_MONO, ROW_PAIR, PAIR_LOW},
      '{-SMP_ONE, CH_FL, CNT_MONO, ROW_PAIR, PAIR_LOW},
      // bad counts and an index past the count are dropped
      '{SMP_ONE, CH_FL, 7'd0, ROW_NONE, PAIR_NONE},
      '{SMP_ONE, CH_FL, 7'd65, ROW_NONE, PAIR_NONE},
      '{SMP_MAX, 6'd63, 7'd127, ROW_NONE, PAIR_NONE},
      '{SMP_ONE, 6'd5, 7'd3, ROW_NONE, PAIR_NONE},
      '{SMP_ONE, CH_FL, CNT_STEREO, ROW_NONE, PAIR_NONE},
      '{-SMP_ONE, CH_FR, CNT_STEREO, ROW_PAIR, PAIR_SPLIT},
      '{SMP_MAX, CH_FL, CNT_7_1, ROW_PREDICT, PAIR_NONE},
      '{SMP_MIN, CH_FR, CNT_7_1, ROW_PREDICT, PAIR_NONE},
      '{SMP_ONE, CH_C, CNT_7_1, ROW_PREDICT, PAIR_NONE},
      '{SMP_MAX, CH_LFE, CNT_7_1, ROW_PREDICT, PAIR_NONE},
      '{-SMP_ONE, CH_SL, CNT_7_1, ROW_PREDICT, PAIR_NONE},
      '{SMP_HALF, CH_SR, CNT_7_1, ROW_PREDICT, PAIR_NONE},
      '{SMP_MIN, CH_BL, CNT_7_1, ROW_PREDICT, PAIR_NONE},
      '{SMP_MAX, CH_BR, CNT_7_1, ROW_PREDICT, PAIR_NONE},
      '{SMP_ONE, 6'd0, 7'd3, ROW_NONE, PAIR_NONE},
      '{SMP_ONE, 6'd1, 7'd3, ROW_NONE, PAIR_NONE},
      '{SMP_ONE, 6'd2, 7'd3, ROW_PAIR, PAIR_HIGH},
      // frame without channel 0 keeps whatever was summed before
      '{-SMP_HALF, 6'd1, 7'd4, ROW_PREDICT, PAIR_NONE},
      '{SMP_HALF, 6'd3, 7'd4, ROW_PREDICT, PAIR_NONE}
   };

   multichannel_stereo_downmix_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   function automatic logic signed [OUT_W-1:0] to_pcm(input longint level);
      longint full = longint'(1) <<< ONE_SHIFT;
      if (level > full) level = full;
      if (level < -full) level = -full;
      return OUT_W'((level * longint'(FULL_SCALE)) / full);
   endfunction

   // Returns 1 when the sample closes a frame and a stereo pair comes out.
   function automatic bit downmix_predict(input logic signed [SMP_W-1:0] smp,
         input logic [CH_W-1:0] ch, input logic [CNT_W-1:0] cnt,
         output stereo_pcm_type pair);
      longint s;
      longint unit;
      longint prod;
      longint l;
      longint r;
      dmx_mode_type mode;
      pair = '0;
      if (cnt == 0 || cnt > MAX_CHANNELS_DEF || ch >= cnt) return 1'b0;
      s = longint'(smp);
      unit = s <<< UNIT_SHIFT;
      if (cnt == CNT_MONO) begin
         mode = MODE_UNIT;
      end else if (cnt == CNT_STEREO || cnt == CNT_5_1 || cnt == CNT_7_1) begin
         mode = MODE_MATRIX;
      end else begin
         mode = MODE_AVG;
      end
      if (ch == CH_FL) begin
         left_acc = 0;
         right_acc = 0;
      end
      case (mode)
         MODE_UNIT: begin
            left_acc += unit;
            right_acc += unit;
         end
         MODE_MATRIX: begin
            prod = (ch < GAIN_COUNT) ? s * longint'(gain_reg[ch[GAIN_IDX_W-1:0]]) : 0;
            case (ch)
               CH_FL, CH_SL, CH_BL: left_acc += prod;
               CH_FR, CH_SR, CH_BR: right_acc += prod;
               CH_C, CH_LFE: begin
                  left_acc += prod;
                  right_acc += prod;
               end
               default: ;
            endcase
         end
         default: begin
            if (ch[0]) right_acc += unit;
            else left_acc += unit;
         end
      endcase
      if (ch != cnt - 1) return 1'b0;
      l = left_acc;
      r = right_acc;
      if (mode == MODE_AVG) begin
         // even channels feed left, odd feed right; divide truncates toward zero
         l = l / ((longint'(cnt) + 1) / 2);
         r = r / (longint'(cnt) / 2);
      end
      pair.left = to_pcm(l);
      pair.right = to_pcm(r);
      left_acc = 0;
      right_acc = 0;
      return 1'b1;
   endfunction

   function automatic logic signed [SMP_W-1:0] random_sample();
      int unsigned pick = $urandom_range(99);
      if (pick < 40) return SMP_W'($urandom);
      if (pick < 85) return SMP_W'(int'($urandom_range(2 * 1048576)) - 1048576);
      case ($urandom_range(3))
         0: return SMP_MAX;
         1: return SMP_MIN;
         2: return SMP_ONE;
         default: return -SMP_ONE;
      endcase
   endfunction

   function automatic void flag_error(input string what);
      pcm_errors++;
      if (pcm_errors <= ERRORS_SHOWN) $display("%0t: %s", $time, what);
   endfunction

   // Returns at the rising edge where the request was taken.
   task automatic send_sample(input logic signed [SMP_W-1:0] smp,
         input logic [CH_W-1:0] ch, input logic [CNT_W-1:0] cnt,
         input row_kind_type kind, input stereo_pcm_type typed);
      stereo_pcm_type predicted;
      bit has_pair;
      @(negedge clock);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.sample_value <= smp;
      req_ch.channel_index <= ch;
      req_ch.channel_count <= cnt;
      do @(posedge clock); while (!req_ch.ready);
      has_pair = downmix_predict(smp, ch, cnt, predicted);
      if (kind == ROW_PAIR) pcm_expected.push_back(typed);
      else if (kind == ROW_PREDICT && has_pair) pcm_expected.push_back(predicted);
   endtask

   // A request the block must drop: zero count, count too large, or index past count.
   task automatic send_ignored();
      logic [CNT_W-1:0] cnt;
      logic [CH_W-1:0] ch;
      ch = CH_W'($urandom);
      case ($urandom_range(2))
         0: cnt = '0;
         1: cnt = CNT_W'($urandom_range(MAX_CHANNELS_DEF + 1, 127));
         default: begin
            cnt = CNT_W'($urandom_range(1, 63));
            ch = CH_W'($urandom_range(cnt, 63));
         end
      endcase
      send_sample(random_sample(), ch, cnt, ROW_PREDICT, PAIR_NONE);
   endtask

   task automatic drain(input int unsigned settle);
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pcm_expected.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic run_phase(input int unsigned quota, input bit hold_midway);
      int unsigned done;
      int unsigned pick;
      int first;
      int last;
      int skip;
      int noise_at;
      bit held;
      logic [CNT_W-1:0] cnt;
      done = 0;
      held = 1'b0;
      while (done < quota) begin
         if (hold_midway && !held && done >= quota / 2) begin
            held = 1'b1;
            drain(0);
         end
         pick = $urandom_range(99);
         if (pick < 10) cnt = CNT_MONO;
         else if (pick < 25) cnt = CNT_STEREO;
         else if (pick < 40) cnt = CNT_5_1;
         else if (pick < 60) cnt = CNT_7_1;
         else if (pick < 85) begin
            cnt = CNT_W'($urandom_range(3, 7));
            if (cnt == CNT_5_1) cnt = CNT_W'(3);
         end else if (pick < 97) cnt = CNT_W'($urandom_range(9, MAX_CHANNELS_DEF - 1));
         else cnt = CNT_W'(MAX_CHANNELS_DEF);
         first = 0;
         last = int'(cnt) - 1;
         skip = -1;
         noise_at = -1;
         pick = $urandom_range(99);
         if (pick < 5) first = $urandom_range(last);
         else if (pick < 10) last = last - 1;
         else if (pick < 15) skip = $urandom_range(last);
         else if (pick < 20) noise_at = $urandom_range(last);
         for (int c = first; c <= last; c++) begin
            if (c == noise_at) send_ignored();
            if (c != skip) begin
               send_sample(random_sample(), CH_W'(c), cnt, ROW_PREDICT, PAIR_NONE);
               done++;
            end
         end
         if (pick >= 20 && pick < 24) send_ignored();
      end
   endtask

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin : check_results
      stereo_pcm_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pcm_expected.size() == 0) begin
            flag_error($sformatf("unexpected result left %0d right %0d",
               rsp_ch.left_out, rsp_ch.right_out));
         end else begin
            want = pcm_expected.pop_front();
            if (rsp_ch.left_out !== want.left)
               flag_error($sformatf("left_out expected %0d got %0d", want.left,
                  rsp_ch.left_out));
            if (rsp_ch.right_out !== want.right)
               flag_error($sformatf("right_out expected %0d got %0d", want.right,
                  rsp_ch.right_out));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("multichannel_stereo_downmix_top verification failed");
         $finish;
      end
   end

   initial begin : stimulus
      logic [GAIN_W-1:0] gain_val;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.sample_value = '0;
      req_ch.channel_index = '0;
      req_ch.channel_count = '0;
      rsp_ch.ready = 1'b0;
      for (int g = 0; g < GAIN_COUNT; g++) gain_reg[g] = GAIN_RESET[g];
      left_acc = 0;
      right_acc = 0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_sample(directed_rows[i].smp, directed_rows[i].ch, directed_rows[i].cnt,
            directed_rows[i].kind, directed_rows[i].pair);

      // phase 0 keeps reset gains, 1 all max, 2 all zero, 5 reset values written back
      for (int p = 0; p < PHASES; p++) begin
         drain(SETTLE_CYCLES);
         if (p != 0) begin
            for (int g = 0; g < GAIN_COUNT; g++) begin
               case (p)
                  1: gain_val = '1;
                  2: gain_val = '0;
                  5: gain_val = GAIN_RESET[g];
                  default: gain_val = GAIN_W'($urandom);
               endcase
               csr_we <= 1'b1;
               csr_index <= CSR_IDX_W'(g);
               csr_wdata <= gain_val;
               gain_reg[g] = gain_val;
               @(negedge clock);
            end
            // a write past the last gain must change nothing
            csr_index <= CSR_IDX_W'($urandom_range(GAIN_COUNT, CSR_TOP));
            csr_wdata <= GAIN_W'($urandom);
            @(negedge clock);
            csr_we <= 1'b0;
         end
         case (p % 4)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 56;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 56;
            end
            default: begin
               send_idle_pct = 17;
               recv_stall_pct = 17;
            end
         endcase
         run_phase(ITEMS_PER_PHASE, p == 1);
      end
      drain(SETTLE_CYCLES);

      if (pcm_errors == 0 && pcm_expected.size() == 0) begin
         $display("multichannel_stereo_downmix_top verification clean");
      end else begin
         $display("multichannel_stereo_downmix_top verification failed");
      end
      $finish;
   end

endmodule
